>>> hdl/all_pairs_sphere_overlap_assert.svh
// ----------------------------------------------------------------------------
// all_pairs_sphere_overlap_assert.svh
// Assertion macros for the sphere overlap block; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef ALL_PAIRS_SPHERE_OVERLAP_ASSERT_SVH
`define ALL_PAIRS_SPHERE_OVERLAP_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every clock edge.
`define APSO_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("apso: invariant violated");

// Check a consequence in the same cycle.
`define APSO_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("apso: implication violated");

// Check a consequence in the following cycle.
`define APSO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("apso: next-cycle check violated");

`else

`define APSO_ASSERT_ALWAYS(label, expr)
`define APSO_ASSERT_IMPLY(label, ante, cons)
`define APSO_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> hdl/apso_pkg.sv
// ----------------------------------------------------------------------------
// apso_pkg
// Types, constants and helpers shared by the sphere overlap block.
// ----------------------------------------------------------------------------
package apso_pkg;

    localparam int MAX_SPHERES = 8;
    localparam int IDX_W       = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int CNT_W       = $clog2(MAX_SPHERES + 1);
    localparam int COORD_W     = 16;
    localparam int RAD_W       = 15;
    localparam int SPH_W       = 3 * COORD_W + RAD_W;
    localparam int OPND_W      = 16;
    localparam int PROD_W      = 2 * OPND_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int OUT_IDX_W   = 3;
    localparam int PAIR_W      = 5;
    localparam logic [PAIR_W-1:0] PAIR_MAX = '1;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic [RAD_W-1:0]          radius;
        logic                      last_sphere;
    } t_in_item;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] index_a;
        logic [OUT_IDX_W-1:0] index_b;
        logic                 is_pair;
        logic [PAIR_W-1:0]    pair_count;
        logic                 overflowed;
        logic                 last_result;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [RAD_W-1:0]          r;
    } t_sphere;

    typedef enum logic [2:0] {
        S_LOAD,
        S_RD_A,
        S_GET_A,
        S_WAIT_B,
        S_CALC,
        S_CMP,
        S_EMIT,
        S_TERM
    } t_state;

    // Control of the shared square-and-accumulate unit
    typedef struct packed {
        logic mul_en;
        logic acc_clear;
        logic acc_en;
    } t_sq_ctrl;

    // Magnitude of b - a; fits 16 bits for any pair of 16-bit inputs
    function automatic logic [OPND_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        d = $signed({b[COORD_W-1], b}) - $signed({a[COORD_W-1], a});
        if (d < 0) begin
            d = -d;
        end
        return d[OPND_W-1:0];
    endfunction

endpackage

>>> hdl/all_pairs_sphere_overlap.sv
// ----------------------------------------------------------------------------
// all_pairs_sphere_overlap
// Brute-force sphere-sphere overlap check over one loaded set of spheres.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------
//  in      | sink      | i_in_valid / o_in_stall   | i_in  (t_in_item)
//  out     | source    | o_out_valid / i_out_stall | o_out (t_out_item)
//
//  Loading accepts one sphere per cycle. After the sphere marked last, the
//  sequencer walks every pair i < j through one shared squarer: a RAM read
//  per outer index, then per pair a read, four squares and a compare, plus
//  an emit step for an overlapping pair, and at the end the terminator.
//  The input is stalled for the whole check; a stalled output holds the
//  sequencer in its emit or terminator state. Reset needs no clearing pass:
//  the store is only read below the fill count.
//
module all_pairs_sphere_overlap import apso_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    `include "all_pairs_sphere_overlap_assert.svh"

    // Control state
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_j, n_j;
    logic [1:0]       r_k, n_k;
    logic [PAIR_W-1:0] r_pairs, n_pairs;
    logic             r_out_valid, n_out_valid;

    // Payload
    t_sphere          r_sa;
    t_out_item        r_out, n_out;

    // Store and shared unit
    logic             ram_we;
    logic [IDX_W-1:0] ram_raddr;
    logic [SPH_W-1:0] ram_rdata;
    t_sphere          sb;
    t_sphere          wr_sph;
    t_sq_ctrl         sq_ctrl;
    logic [OPND_W-1:0] sq_opnd;
    logic             in_reach;

    logic             in_acc;
    logic             out_free;
    logic             j_more;
    logic             i_more;
    logic             has_room;
    logic             term_seen;

    assign o_in_stall = (r_state != S_LOAD);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign has_room   = (r_count < CNT_W'(MAX_SPHERES));

    // Pair walk limits, one bit wider than the count so that i + 2 cannot wrap
    assign j_more = ((CNT_W+1)'(r_j) + (CNT_W+1)'(1)) < (CNT_W+1)'(r_count);
    assign i_more = ((CNT_W+1)'(r_i) + (CNT_W+1)'(2)) < (CNT_W+1)'(r_count);

    assign wr_sph = {i_in.center_x, i_in.center_y, i_in.center_z, i_in.radius};

    assign ram_we    = (r_state == S_LOAD) && in_acc && has_room;
    assign ram_raddr = (r_state == S_RD_A) ? r_i : r_j;
    assign sb        = t_sphere'(ram_rdata);

    apso_ram #(
        .WIDTH(SPH_W),
        .DEPTH(MAX_SPHERES)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_count[IDX_W-1:0]),
        .i_wdata(wr_sph),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Feed dx, dy, dz, then the radius sum through the squarer
    always_comb begin
        case (r_k)
            2'd0:    sq_opnd = abs_diff(r_sa.x, sb.x);
            2'd1:    sq_opnd = abs_diff(r_sa.y, sb.y);
            2'd2:    sq_opnd = abs_diff(r_sa.z, sb.z);
            default: sq_opnd = OPND_W'(r_sa.r) + OPND_W'(sb.r);
        endcase
    end

    apso_sq_unit u_sq (
        .i_clk     (i_clk),
        .i_ctrl    (sq_ctrl),
        .i_opnd    (sq_opnd),
        .o_in_reach(in_reach)
    );

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_pairs     = r_pairs;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        sq_ctrl     = '0;

        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    // Store the sphere, or drop it and flag the overflow
                    if (has_room) begin
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.last_sphere) begin
                        n_i     = '0;
                        n_j     = IDX_W'(1);
                        n_pairs = '0;
                        if (n_count < CNT_W'(2)) begin
                            n_state = S_TERM;
                        end else begin
                            n_state = S_RD_A;
                        end
                    end
                end
            end
            S_RD_A: begin
                n_state = S_GET_A;
            end
            S_GET_A: begin
                // Sphere i arrives now; sphere j is read this cycle
                n_state = S_CALC;
                n_k     = '0;
            end
            S_WAIT_B: begin
                n_state = S_CALC;
                n_k     = '0;
            end
            S_CALC: begin
                sq_ctrl.mul_en    = 1'b1;
                sq_ctrl.acc_clear = (r_k == 2'd1);
                sq_ctrl.acc_en    = (r_k == 2'd2) || (r_k == 2'd3);
                n_k = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                sq_ctrl.acc_en = 1'b1;
                if (in_reach) begin
                    n_state = S_EMIT;
                    if (r_pairs != PAIR_MAX) begin
                        n_pairs = r_pairs + PAIR_W'(1);
                    end
                end else if (j_more) begin
                    n_j     = r_j + IDX_W'(1);
                    n_state = S_WAIT_B;
                end else if (i_more) begin
                    n_i     = r_i + IDX_W'(1);
                    n_j     = r_i + IDX_W'(2);
                    n_state = S_RD_A;
                end else begin
                    n_state = S_TERM;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out             = '0;
                    n_out.index_a     = OUT_IDX_W'(r_i);
                    n_out.index_b     = OUT_IDX_W'(r_j);
                    n_out.is_pair     = 1'b1;
                    if (j_more) begin
                        n_j     = r_j + IDX_W'(1);
                        n_state = S_WAIT_B;
                    end else if (i_more) begin
                        n_i     = r_i + IDX_W'(1);
                        n_j     = r_i + IDX_W'(2);
                        n_state = S_RD_A;
                    end else begin
                        n_state = S_TERM;
                    end
                end
            end
            S_TERM: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out             = '0;
                    n_out.pair_count  = r_pairs;
                    n_out.overflowed  = r_ovf;
                    n_out.last_result = 1'b1;
                    // Start the next set empty
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_pairs     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            r_pairs     <= n_pairs;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: hold sphere i for its whole row of pairs
    always_ff @(posedge i_clk) begin
        if (r_state == S_GET_A) begin
            r_sa <= sb;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Set emptied, loading reopened and the terminator on the output
    assign term_seen = (r_count == '0) && !r_ovf && (r_state == S_LOAD)
                       && o_out_valid && o_out.last_result;

    // Fill count never passes the store depth
    `APSO_ASSERT_ALWAYS(a_count_cap, r_count <= CNT_W'(MAX_SPHERES))

    // A pair under test is ordered and lies inside the filled part of the store
    `APSO_ASSERT_IMPLY(a_pair_range, r_state == S_CALC, (r_i < r_j) && (CNT_W'(r_j) < r_count))

    // Sending the terminator empties the set and reopens loading
    `APSO_ASSERT_NEXT(a_term_clear, (r_state == S_TERM) && out_free, term_seen)

endmodule

>>> hdl/apso_ram.sv
// ----------------------------------------------------------------------------
// apso_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module apso_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/apso_sq_unit.sv
// ----------------------------------------------------------------------------
// apso_sq_unit
// Shared squarer with accumulator and compare against the last square.
// ----------------------------------------------------------------------------
module apso_sq_unit import apso_pkg::*; (
    input  logic              i_clk,
    input  t_sq_ctrl          i_ctrl,
    input  logic [OPND_W-1:0] i_opnd,
    output logic              o_in_reach
);

    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= i_opnd * i_opnd;
        end
        if (i_ctrl.acc_clear) begin
            r_acc <= ACC_W'(r_prod);
        end else if (i_ctrl.acc_en) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Sum of squares held in the accumulator, radius-sum square in the product
    assign o_in_reach = (r_acc <= ACC_W'(r_prod));

endmodule

>>> sim/sphere_overlap_checker.sv
// ----------------------------------------------------------------------------
// sphere_overlap_checker
// Watches both channels of the sphere overlap block. It predicts the pair
// records and terminator of every sphere set and compares each result
// transaction field by field, in order.
// ----------------------------------------------------------------------------
module sphere_overlap_checker import apso_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_in_item          sphere_set [MAX_SPHERES];
    int                loaded = 0;
    bit                dropped = 1'b0;
    t_out_item         expected_q [$];
    t_out_item         rec;
    logic [PAIR_W-1:0] hits;
    int                fail_count = 0;

    // Exact test on squares: |b - a|^2 <= (ra + rb)^2, touching included
    function automatic bit spheres_overlap(input t_in_item a, input t_in_item b);
        int                dx;
        int                dy;
        int                dz;
        longint unsigned   dist2;
        longint unsigned   reach;
        dx    = $signed(b.center_x) - $signed(a.center_x);
        dy    = $signed(b.center_y) - $signed(a.center_y);
        dz    = $signed(b.center_z) - $signed(a.center_z);
        dist2 = longint'(dx) * dx + longint'(dy) * dy + longint'(dz) * dz;
        reach = longint'(a.radius) + longint'(b.radius);
        return dist2 <= reach * reach;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            loaded  = 0;
            dropped = 1'b0;
            expected_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                if (loaded < MAX_SPHERES) begin
                    sphere_set[loaded] = i_in;
                    loaded++;
                end else begin
                    dropped = 1'b1;
                end
                if (i_in.last_sphere) begin
                    hits = '0;
                    for (int ia = 0; ia < loaded; ia++) begin
                        for (int ib = ia + 1; ib < loaded; ib++) begin
                            if (spheres_overlap(sphere_set[ia], sphere_set[ib])) begin
                                rec         = '0;
                                rec.index_a = ia[OUT_IDX_W-1:0];
                                rec.index_b = ib[OUT_IDX_W-1:0];
                                rec.is_pair = 1'b1;
                                expected_q  = {expected_q, rec};
                                if (hits < PAIR_MAX) begin
                                    hits++;
                                end
                            end
                        end
                    end
                    rec             = '0;
                    rec.pair_count  = hits;
                    rec.overflowed  = dropped;
                    rec.last_result = 1'b1;
                    expected_q      = {expected_q, rec};
                    loaded  = 0;
                    dropped = 1'b0;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result transaction: %p", i_out);
                    fail_count++;
                end else begin
                    rec = expected_q.pop_front();
                    check_field("index_a", rec.index_a, i_out.index_a);
                    check_field("index_b", rec.index_b, i_out.index_b);
                    check_field("is_pair", rec.is_pair, i_out.is_pair);
                    check_field("pair_count", rec.pair_count, i_out.pair_count);
                    check_field("overflowed", rec.overflowed, i_out.overflowed);
                    check_field("last_result", rec.last_result, i_out.last_result);
                end
            end
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fail_count;
    end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench top for all_pairs_sphere_overlap. Loads directed sphere sets
// (single sphere, exact touching, extreme coordinates, store overflow), then
// random sets of varied size and spread under several idle and stall mixes.
// The checker beside the block predicts and compares; this module only
// drives stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb import apso_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // Generous bound: ~170 items in ~35 sets, each set giving up to 29 results
    // that may each sit out a long stall.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int PHASE_ITEMS   = 34;

    // Coordinate spread of one random set
    typedef enum int {
        SPREAD_FULL,
        SPREAD_CLUSTER,
        SPREAD_TINY,
        SPREAD_WIDE_RADIUS
    } t_spread;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;

    int idle_pct    = 0;
    int stall_pct   = 0;
    int cycle_count = 0;
    int fail_count;
    int pending;

    all_pairs_sphere_overlap dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    sphere_overlap_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver side: stall at random with the current phase's rate
    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: end the run as failed once the cycle limit is reached
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** all_pairs_sphere_overlap: FAILED **");
            $finish;
        end
    end

    function automatic t_in_item sphere(input int x, input int y, input int z,
                                        input int r, input bit last);
        t_in_item s;
        s.center_x    = 16'(x);
        s.center_y    = 16'(y);
        s.center_z    = 16'(z);
        s.radius      = 15'(r);
        s.last_sphere = last;
        return s;
    endfunction

    // Pick one sphere of a set; bx/by/bz anchor the cluster spread
    function automatic t_in_item random_sphere(input t_spread spread, input int bx,
                                               input int by, input int bz);
        t_in_item s;
        case (spread)
            SPREAD_CLUSTER: begin
                s = sphere(bx + int'($urandom_range(1023)) - 512,
                           by + int'($urandom_range(1023)) - 512,
                           bz + int'($urandom_range(1023)) - 512,
                           $urandom_range(600), 1'b0);
            end
            SPREAD_TINY: begin
                // small integers make exact touching common
                s = sphere(int'($urandom_range(12)) - 6, int'($urandom_range(12)) - 6,
                           int'($urandom_range(12)) - 6, $urandom_range(6), 1'b0);
            end
            SPREAD_WIDE_RADIUS: begin
                s = sphere($urandom, $urandom, $urandom,
                           $urandom_range(32767, 16384), 1'b0);
            end
            default: begin
                s = sphere($urandom, $urandom, $urandom, $urandom, 1'b0);
            end
        endcase
        return s;
    endfunction

    // Present one sphere and hold it until the block takes it. Entered and
    // left at a falling edge; valid gets one assignment per falling edge.
    task automatic send_sphere(input t_in_item s);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= s;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Hold the sender off until every predicted result has been seen
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) begin
            @(negedge clk);
        end
    endtask

    // Send whole sets with random content until the item goal is met
    task automatic send_random_sets(input int item_goal);
        int       sent;
        int       pick;
        int       set_size;
        int       bx;
        int       by;
        int       bz;
        t_spread  spread;
        t_in_item s;
        sent = 0;
        while (sent < item_goal) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                set_size = 1;
            end else if (pick < 22) begin
                set_size = MAX_SPHERES + $urandom_range(3, 1);
            end else begin
                set_size = $urandom_range(MAX_SPHERES, 2);
            end
            spread = t_spread'($urandom_range(3));
            bx = int'($urandom_range(32767)) - 16384;
            by = int'($urandom_range(32767)) - 16384;
            bz = int'($urandom_range(32767)) - 16384;
            for (int k = 0; k < set_size; k++) begin
                s = random_sphere(spread, bx, by, bz);
                s.last_sphere = (k == set_size - 1);
                send_sphere(s);
                sent++;
            end
        end
    endtask

    initial begin
        // Hold reset, then release it at a falling edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed sets, no idling
        // single sphere: terminator only
        send_sphere(sphere(0, 0, 0, 0, 1'b1));
        // coincident points with zero radius: distance 0 equals reach 0
        send_sphere(sphere(5, 5, 5, 0, 1'b0));
        send_sphere(sphere(5, 5, 5, 0, 1'b1));
        // 3-4-12-13 triangle: exactly touching, then one step apart
        send_sphere(sphere(0, 0, 0, 100, 1'b0));
        send_sphere(sphere(300, 400, 1200, 1200, 1'b1));
        send_sphere(sphere(0, 0, 0, 100, 1'b0));
        send_sphere(sphere(300, 400, 1200, 1199, 1'b1));
        // opposite corners with full radius: well out of reach
        send_sphere(sphere(-32768, -32768, -32768, 32767, 1'b0));
        send_sphere(sphere(32767, 32767, 32767, 32767, 1'b1));
        // axis extremes against the origin: only the 32767 pair touches
        send_sphere(sphere(-32768, 0, 0, 32767, 1'b0));
        send_sphere(sphere(32767, 0, 0, 32767, 1'b0));
        send_sphere(sphere(0, 0, 0, 0, 1'b1));
        // overfull set: every stored pair overlaps, two spheres dropped
        for (int k = 0; k < MAX_SPHERES + 2; k++) begin
            send_sphere(sphere(-1, 0, 1, 256 + k, k == MAX_SPHERES + 1));
        end
        wait_drained();

        // Random phases: none, sender idle, receiver stall, both
        send_random_sets(PHASE_ITEMS);
        wait_drained();

        idle_pct  = 68;
        stall_pct = 0;
        send_random_sets(PHASE_ITEMS);
        wait_drained();

        idle_pct  = 0;
        stall_pct = 68;
        send_random_sets(PHASE_ITEMS);
        wait_drained();

        idle_pct  = 28;
        stall_pct = 28;
        send_random_sets(PHASE_ITEMS);

        // Drain, then allow a tail for any stray result
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("** all_pairs_sphere_overlap: PASSED **");
        end else begin
            $display("** all_pairs_sphere_overlap: FAILED **");
        end
        $finish;
    end

endmodule
